/* rtl/core/ltcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltcd_pkg
// Shared types and constants of the LRU tag cache directory.
// ----------------------------------------------------------------------------
package ltcd_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int KEY_BITS   = 16;
  localparam int STAMP_BITS = 32;

  // fixed field widths of the item and result ports
  localparam int OWNER_W     = 4;
  localparam int FRAME_KEY_W = 16;
  localparam int OUTCOME_W   = 2;
  localparam int STATUS_W    = 3;
  localparam int SLOT_IDX_W  = 3;
  localparam int COUNT_W     = 4;

  // accepted owner ids: 0 up to OWNER_LAST, and OWNER_ALT
  localparam logic [OWNER_W-1:0] OWNER_LAST = 4'd6;
  localparam logic [OWNER_W-1:0] OWNER_ALT  = 4'd8;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [OUTCOME_W-1:0] FILL_OK        = 2'd0;
  localparam logic [OUTCOME_W-1:0] FILL_FAIL_PRE  = 2'd1;
  localparam logic [OUTCOME_W-1:0] FILL_FAIL_POST = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STS_HIT     = 3'd0,
    STS_FILLED  = 3'd1,
    STS_REJECT  = 3'd2,
    STS_FAIL    = 3'd3,
    STS_CLEARED = 3'd4
  } status_e;

  typedef struct packed {
    logic [OWNER_W-1:0]    owner;
    logic [KEY_BITS-1:0]   key;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/ltcd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ltcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/core/lru_tag_cache_directory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tag_cache_directory
// Eight-slot fully associative cache directory with timestamp LRU.
// ----------------------------------------------------------------------------
// Usage:
//   An item (func_i, owner_id_i, frame_key_i, fill_outcome_i) is taken at a
//   rising edge with start high and busy low. One result per item comes back
//   on status_o, slot_index_o, replaced_valid_o and cached_count_o, marked by
//   done_o for exactly one cycle; the receiver cannot stall it.
//   Clear and rejected-id items skip the scan: done_o is high in the cycle
//   after acceptance and busy stays low, so the next item may follow at once.
//   A lookup reads the tag/stamp RAM one slot per cycle over its single
//   registered read port, then updates the directory in S_DONE; done_o is
//   high in the first cycle with busy low. No new item is taken while busy,
//   so lookups do not overlap; the slot scan over the RAM sets their pace.
//   Valid bits and the stamp counter sit in flops; reset (rst_ni low) clears
//   them at once, so the RAM content needs no clearing pass.
// ----------------------------------------------------------------------------
module lru_tag_cache_directory (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [ltcd_pkg::OWNER_W-1:0]      owner_id_i,
  input  logic [ltcd_pkg::FRAME_KEY_W-1:0]  frame_key_i,
  input  logic [ltcd_pkg::OUTCOME_W-1:0]    fill_outcome_i,
  output logic                              done_o,
  output logic [ltcd_pkg::STATUS_W-1:0]     status_o,
  output logic [ltcd_pkg::SLOT_IDX_W-1:0]   slot_index_o,
  output logic                              replaced_valid_o,
  output logic [ltcd_pkg::COUNT_W-1:0]      cached_count_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ltcd_pkg::SLOT_W:0]          idx_q, idx_d;
  logic                               rd_vld_q, rd_vld_d;
  logic [ltcd_pkg::SLOT_W-1:0]        rd_idx_q, rd_idx_d;
  logic [ltcd_pkg::SLOTS-1:0]         valid_q, valid_d;
  logic [ltcd_pkg::STAMP_BITS-1:0]    counter_q, counter_d;
  logic                               hit_q, hit_d;
  logic [ltcd_pkg::SLOT_W-1:0]        hit_idx_q, hit_idx_d;
  logic [ltcd_pkg::SLOT_W-1:0]        best_idx_q, best_idx_d;
  logic [ltcd_pkg::STAMP_BITS-1:0]    best_stamp_q, best_stamp_d;
  logic                               done_q, done_d;

  // item payload
  logic [ltcd_pkg::OWNER_W-1:0]       owner_q;
  logic [ltcd_pkg::KEY_BITS-1:0]      key_q;
  logic [ltcd_pkg::OUTCOME_W-1:0]     outcome_q;
  logic                               load;

  // result payload
  ltcd_pkg::status_e                  status_q, status_d;
  logic [ltcd_pkg::SLOT_W-1:0]        slot_q, slot_d;
  logic                               repl_q, repl_d;
  logic [ltcd_pkg::CNT_W-1:0]         count_q, count_d;

  // RAM ports
  logic                               issue;
  logic                               ram_we;
  logic [ltcd_pkg::SLOT_W-1:0]        ram_waddr;
  ltcd_pkg::entry_t                   ram_wdata;
  logic [ltcd_pkg::ENTRY_W-1:0]       ram_rdata;
  ltcd_pkg::entry_t                   rd_entry;

  logic                               owner_ok;
  logic                               any_inv;
  logic [ltcd_pkg::SLOT_W-1:0]        first_inv;
  logic [ltcd_pkg::SLOT_W-1:0]        victim;
  logic [ltcd_pkg::STAMP_BITS-1:0]    stamp_next;

  assign rd_entry   = ram_rdata;
  assign owner_ok   = (owner_id_i inside {[4'd0 : ltcd_pkg::OWNER_LAST], ltcd_pkg::OWNER_ALT});
  assign issue      = (state_q == S_SCAN) && (idx_q < (ltcd_pkg::SLOT_W + 1)'(ltcd_pkg::SLOTS));
  assign stamp_next = counter_q + 1'b1;
  assign any_inv    = ~&valid_q;
  assign victim     = any_inv ? first_inv : best_idx_q;

  always_comb begin
    first_inv = '0;
    for (int i = ltcd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        first_inv = ltcd_pkg::SLOT_W'(i);
      end
    end
  end

  ltcd_ram #(
    .WIDTH (ltcd_pkg::ENTRY_W),
    .DEPTH (ltcd_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (idx_q[ltcd_pkg::SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    rd_vld_d     = issue;
    rd_idx_d     = idx_q[ltcd_pkg::SLOT_W-1:0];
    valid_d      = valid_q;
    counter_d    = counter_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    done_d       = 1'b0;
    load         = 1'b0;
    status_d     = status_q;
    slot_d       = '0;
    repl_d       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = victim;
    ram_wdata    = '{owner: owner_q, key: key_q, stamp: stamp_next};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (func_i == ltcd_pkg::FUNC_CLEAR) begin
            valid_d   = '0;
            counter_d = '0;
            done_d    = 1'b1;
            status_d  = ltcd_pkg::STS_CLEARED;
          end else if (!owner_ok) begin
            done_d   = 1'b1;
            status_d = ltcd_pkg::STS_REJECT;
          end else begin
            load    = 1'b1;
            hit_d   = 1'b0;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (!hit_q && valid_q[rd_idx_q] && rd_entry.owner == owner_q &&
              rd_entry.key == key_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
          end
          // strict less keeps the lowest index on equal stamps
          if (rd_idx_q == '0 || rd_entry.stamp < best_stamp_q) begin
            best_stamp_d = rd_entry.stamp;
            best_idx_d   = rd_idx_q;
          end
          if (rd_idx_q == ltcd_pkg::SLOT_W'(ltcd_pkg::SLOTS - 1)) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (hit_q) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx_q;
          counter_d = stamp_next;
          status_d  = ltcd_pkg::STS_HIT;
          slot_d    = hit_idx_q;
        end else if (outcome_q == ltcd_pkg::FILL_OK) begin
          ram_we          = 1'b1;
          counter_d       = stamp_next;
          valid_d[victim] = 1'b1;
          status_d        = ltcd_pkg::STS_FILLED;
          slot_d          = victim;
          repl_d          = valid_q[victim];
        end else if (outcome_q == ltcd_pkg::FILL_FAIL_POST) begin
          valid_d[victim] = 1'b0;
          status_d        = ltcd_pkg::STS_FAIL;
          slot_d          = victim;
          repl_d          = valid_q[victim];
        end else begin
          status_d = ltcd_pkg::STS_FAIL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d = '0;
    for (int i = 0; i < ltcd_pkg::SLOTS; i++) begin
      count_d = count_d + ltcd_pkg::CNT_W'(valid_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      valid_q   <= '0;
      counter_q <= '0;
      hit_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      valid_q   <= valid_d;
      counter_q <= counter_d;
      hit_q     <= hit_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    hit_idx_q    <= hit_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    if (load) begin
      owner_q   <= owner_id_i;
      key_q     <= frame_key_i[ltcd_pkg::KEY_BITS-1:0];
      outcome_q <= fill_outcome_i;
    end
    if (done_d) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      repl_q   <= repl_d;
      count_q  <= count_d;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign slot_index_o     = ltcd_pkg::SLOT_IDX_W'(slot_q);
  assign replaced_valid_o = repl_q;
  assign cached_count_o   = ltcd_pkg::COUNT_W'(count_q);

endmodule

/* rtl/core/ltcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltcd_checker
// Port-level checks of the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module ltcd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              func_i,
  input logic                              done_o,
  input logic [ltcd_pkg::STATUS_W-1:0]     status_o,
  input logic [ltcd_pkg::SLOT_IDX_W-1:0]   slot_index_o,
  input logic                              replaced_valid_o,
  input logic [ltcd_pkg::COUNT_W-1:0]      cached_count_o
);

  // a clear item answers in the next cycle with an empty directory
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == ltcd_pkg::FUNC_CLEAR) |=>
      (done_o && status_o == ltcd_pkg::STS_CLEARED && cached_count_o == '0))
    else $error("clear item did not give an empty cleared result");

  // a lookup ends with its result in the cycle busy drops
  a_lookup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("lookup finished without a result strobe");

  // busy only rises from an accepted item
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // no slot is touched by a rejected id
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ltcd_pkg::STS_REJECT) |->
      (slot_index_o == '0 && !replaced_valid_o))
    else $error("rejected item reports a slot");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cached_count_o <= ltcd_pkg::COUNT_W'(ltcd_pkg::SLOTS)))
    else $error("cached count beyond slot total");

endmodule

bind lru_tag_cache_directory ltcd_checker u_ltcd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .func_i           (func_i),
  .done_o           (done_o),
  .status_o         (status_o),
  .slot_index_o     (slot_index_o),
  .replaced_valid_o (replaced_valid_o),
  .cached_count_o   (cached_count_o)
);
